// ===== rtl/buddy_free_coalesce_defines.svh =====
// ----------------------------------------------------------------------------
// buddy_free_coalesce_defines.svh
// Assertion macros used by the checker file of the buddy free block.
// ----------------------------------------------------------------------------
`ifndef BUDDY_FREE_COALESCE_DEFINES_SVH
`define BUDDY_FREE_COALESCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy_free_coalesce: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy_free_coalesce: next-cycle check failed");

`endif

// ===== rtl/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared constants, status codes and controller/datapath interface structs
// for the buddy free-and-coalesce block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

  // Default sizing
  localparam int FRAMES_DEF    = 4096;
  localparam int MAX_ORDER_DEF = 12;

  // Address split: 4 KiB pages
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int LIM_W      = PFN_W + 1;

  // Result field widths
  localparam int STATUS_W  = 3;
  localparam int IDX_OUT_W = 12;
  localparam int ORD_OUT_W = 4;

  // Configuration register file
  localparam int FC_W       = 13;
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_FRAME_COUNT = 2'h0;
  localparam logic [FC_W-1:0]       FRAME_COUNT_RST = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_RANGE      = 3'd2,
    ST_NOT_HEADER = 3'd3,
    ST_FREED      = 3'd4
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    clr;       // write reset word at sweep pointer, advance it
    logic    load;      // capture the request address
    logic    rd_self;   // read page map at the request index
    logic    take_ord;  // latch order of the request block
    logic    rd_buddy;  // read page map at the buddy index
    logic    merge;     // retire upper half, step index and order
    logic    fin;       // write final free header
    logic    emit;      // drive one result transaction
    status_t code;      // status for the emitted result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic misaligned;
    logic out_of_range;
    logic not_header;
    logic already_free;
    logic stop;
    logic buddy_ok;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bfc_ram.sv =====
// ----------------------------------------------------------------------------
// bfc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfc_datapath.sv =====
// ----------------------------------------------------------------------------
// bfc_datapath
// Page map storage, request index and order registers, buddy arithmetic and
// the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_datapath #(
  parameter int FRAMES    = bfc_pkg::FRAMES_DEF,
  parameter int MAX_ORDER = bfc_pkg::MAX_ORDER_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bfc_pkg::cmd_t                  cmd,
  output bfc_pkg::sts_t                       sts,
  input  wire logic [bfc_pkg::ADDR_W-1:0]     in_phys_addr,
  input  wire logic [bfc_pkg::FC_W-1:0]       frame_count,
  output logic                                out_valid,
  output logic      [bfc_pkg::STATUS_W-1:0]   out_status,
  output logic      [bfc_pkg::IDX_OUT_W-1:0]  out_block_index,
  output logic      [bfc_pkg::ORD_OUT_W-1:0]  out_block_order
);

  localparam int IDX_W  = $clog2(FRAMES);
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int WORD_W = ORD_W + 2;

  // Request state
  logic                        misal_r;
  logic [bfc_pkg::PFN_W-1:0]   idx_r;
  logic [ORD_W-1:0]            ord_r;
  logic [IDX_W-1:0]            clr_cnt_r;

  // Result registers
  logic                            out_valid_r;
  logic [bfc_pkg::STATUS_W-1:0]    out_status_r;
  logic [bfc_pkg::IDX_OUT_W-1:0]   out_index_r;
  logic [bfc_pkg::ORD_OUT_W-1:0]   out_order_r;

  // Buddy arithmetic
  logic [bfc_pkg::LIM_W-1:0]   lim;
  logic [bfc_pkg::PFN_W-1:0]   bit_mask;
  logic [bfc_pkg::PFN_W-1:0]   buddy;
  logic [bfc_pkg::PFN_W-1:0]   high_idx;
  logic [bfc_pkg::PFN_W-1:0]   low_idx;

  // Page map port signals; word is {order, header, free}
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [WORD_W-1:0]   wdata;
  logic                re;
  logic [IDX_W-1:0]    raddr;
  logic [WORD_W-1:0]   rdata;
  logic [ORD_W-1:0]    rd_ord;
  logic                rd_hdr;
  logic                rd_free;

  // Saturate the usable frame limit at the map depth
  always_comb begin
    if (bfc_pkg::LIM_W'(frame_count) > bfc_pkg::LIM_W'(FRAMES)) begin
      lim = bfc_pkg::LIM_W'(FRAMES);
    end else begin
      lim = bfc_pkg::LIM_W'(frame_count);
    end
  end

  assign bit_mask = bfc_pkg::PFN_W'(1) << ord_r;
  assign buddy    = idx_r ^ bit_mask;
  assign high_idx = idx_r | bit_mask;
  assign low_idx  = idx_r & ~bit_mask;

  assign rd_ord  = rdata[WORD_W-1:2];
  assign rd_hdr  = rdata[1];
  assign rd_free = rdata[0];

  // Select write: sweep, retire upper half, or final header
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = {ORD_W'(0), 1'b1, 1'b0};
    end else if (cmd.merge) begin
      we    = 1'b1;
      waddr = high_idx[IDX_W-1:0];
      wdata = {ord_r, 1'b0, 1'b0};
    end else if (cmd.fin) begin
      we    = 1'b1;
      waddr = idx_r[IDX_W-1:0];
      wdata = {ord_r, 1'b1, 1'b1};
    end
  end

  // Select read: request page or its buddy
  assign re    = cmd.rd_self | cmd.rd_buddy;
  assign raddr = cmd.rd_buddy ? buddy[IDX_W-1:0] : idx_r[IDX_W-1:0];

  bfc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAMES)
  ) u_page_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status toward the controller
  always_comb begin
    sts.clr_last     = (clr_cnt_r == IDX_W'(FRAMES - 1));
    sts.misaligned   = misal_r;
    sts.out_of_range = ({1'b0, idx_r} >= lim);
    sts.not_header   = ~rd_hdr;
    sts.already_free = rd_free;
    sts.stop         = (ord_r >= ORD_W'(MAX_ORDER)) || ({1'b0, buddy} >= lim);
    sts.buddy_ok     = rd_hdr && rd_free && (rd_ord == ord_r);
  end

  // Control registers: sweep pointer and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= in_phys_addr[bfc_pkg::ADDR_W-1:bfc_pkg::PAGE_SHIFT];
      misal_r <= |in_phys_addr[bfc_pkg::PAGE_SHIFT-1:0];
    end else if (cmd.merge) begin
      idx_r <= low_idx;
    end
    if (cmd.take_ord) begin
      ord_r <= rd_ord;
    end else if (cmd.merge) begin
      ord_r <= ord_r + 1'b1;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      if (cmd.code == bfc_pkg::ST_OK) begin
        out_index_r <= bfc_pkg::IDX_OUT_W'(idx_r);
        out_order_r <= bfc_pkg::ORD_OUT_W'(ord_r);
      end else begin
        out_index_r <= '0;
        out_order_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_index = out_index_r;
  assign out_block_order = out_order_r;

endmodule

`default_nettype wire

// ===== rtl/bfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer for the free request: page map sweep after reset, request
// checks, buddy merge loop and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire bfc_pkg::sts_t sts,
  output bfc_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_SELF,
    S_ISSUE,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = bfc_pkg::ST_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (sts.misaligned) begin
          cmd.emit  = 1'b1;
          cmd.code  = bfc_pkg::ST_MISALIGNED;
          state_nxt = S_IDLE;
        end else if (sts.out_of_range) begin
          cmd.emit  = 1'b1;
          cmd.code  = bfc_pkg::ST_RANGE;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_self = 1'b1;
          state_nxt   = S_SELF;
        end
      end
      S_SELF: begin
        if (sts.not_header) begin
          cmd.emit  = 1'b1;
          cmd.code  = bfc_pkg::ST_NOT_HEADER;
          state_nxt = S_IDLE;
        end else if (sts.already_free) begin
          cmd.emit  = 1'b1;
          cmd.code  = bfc_pkg::ST_FREED;
          state_nxt = S_IDLE;
        end else begin
          cmd.take_ord = 1'b1;
          state_nxt    = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts.stop) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_buddy = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.buddy_ok) begin
          cmd.merge = 1'b1;
          state_nxt = S_ISSUE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.fin   = 1'b1;
        cmd.emit  = 1'b1;
        cmd.code  = bfc_pkg::ST_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and busy flag; sweep the page map after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== rtl/buddy_free_coalesce.sv =====
// Order: a misaligned or out-of-range request is rejected in S_ADDR, a header or
// double-free reject in S_SELF after the read of the request page; a good free loops
// S_ISSUE and S_CHECK once per merge and ends in S_FINISH when the order cap, the frame
// limit or the buddy read turns the next merge down. Requests are taken one at a time,
// in S_IDLE only; each merge makes a read and a write on the single page map ports.
// Reset: map swept over all FRAMES words with busy high; writes taken meanwhile.
// ----------------------------------------------------------------------------
// buddy_free_coalesce
// Frees one page block of a buddy allocator and merges it with its freed
// buddies; APB register for the usable frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_free_coalesce #(
  parameter int FRAMES    = bfc_pkg::FRAMES_DEF,
  parameter int MAX_ORDER = bfc_pkg::MAX_ORDER_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Request channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bfc_pkg::ADDR_W-1:0]        in_phys_addr,
  // Result channel
  output logic                                   out_valid,
  output logic      [bfc_pkg::STATUS_W-1:0]      out_status,
  output logic      [bfc_pkg::IDX_OUT_W-1:0]     out_block_index,
  output logic      [bfc_pkg::ORD_OUT_W-1:0]     out_block_order,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bfc_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [bfc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [bfc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  logic [bfc_pkg::FC_W-1:0] frame_count_r;
  logic                     reg_wr;
  bfc_pkg::cmd_t            cmd;
  bfc_pkg::sts_t            sts;

  // Register write on the access phase
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr == bfc_pkg::REG_FRAME_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= bfc_pkg::FRAME_COUNT_RST;
    end else if (reg_wr) begin
      frame_count_r <= pwdata[bfc_pkg::FC_W-1:0];
    end
  end

  // Register read decode
  always_comb begin
    prdata = '0;
    unique case (paddr)
      bfc_pkg::REG_FRAME_COUNT: prdata = bfc_pkg::APB_DATA_W'(frame_count_r);
      default:                  prdata = '0;
    endcase
  end

  bfc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bfc_datapath #(
    .FRAMES    (FRAMES),
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_phys_addr    (in_phys_addr),
    .frame_count     (frame_count_r),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_block_order (out_block_order)
  );

endmodule

`default_nettype wire

// ===== rtl/bfc_checker.sv =====
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks on the buddy free block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_free_coalesce_defines.svh"

module bfc_checker #(
  parameter int MAX_ORDER = bfc_pkg::MAX_ORDER_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_valid,
  input wire logic [bfc_pkg::STATUS_W-1:0]   out_status,
  input wire logic [bfc_pkg::IDX_OUT_W-1:0]  out_block_index,
  input wire logic [bfc_pkg::ORD_OUT_W-1:0]  out_block_order
);

  logic                            ok_result;
  logic                            bad_result;
  logic [bfc_pkg::IDX_OUT_W-1:0]   size_mask;

  assign ok_result  = out_valid && (out_status == bfc_pkg::ST_OK);
  assign bad_result = out_valid && (out_status != bfc_pkg::ST_OK);

  // Index bits below the block size
  assign size_mask = ~({bfc_pkg::IDX_OUT_W{1'b1}} << out_block_order);

  // An accepted transaction keeps the block busy on the next cycle
  `BFC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // One result strobe per transaction, never two in a row
  `BFC_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)

  // A rejected free reports a zero block
  `BFC_ASSERT_NOW(a_reject_zero, bad_result, (out_block_index == '0) && (out_block_order == '0))

  // A merged block never exceeds the top order
  `BFC_ASSERT_NOW(a_order_cap, ok_result, out_block_order <= bfc_pkg::ORD_OUT_W'(MAX_ORDER))

  // A merged block header is aligned to its size
  `BFC_ASSERT_NOW(a_aligned, ok_result, (out_block_index & size_mask) == '0)

endmodule

bind buddy_free_coalesce bfc_checker #(
  .MAX_ORDER (MAX_ORDER)
) u_bfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_block_index (out_block_index),
  .out_block_order (out_block_order)
);

`default_nettype wire
